// ===== design/zci_pkg.sv =====
// Shared constants and controller/datapath interface types for the zero-crossing interpolator.
package zci_pkg;

  localparam int DEF_X_WIDTH     = 32;
  localparam int DEF_Y_WIDTH     = 16;
  localparam int DEF_INDEX_WIDTH = 32;

  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RISING_ENABLE  = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FALLING_ENABLE = 1'd1;

  typedef struct packed {
    logic accept;
    logic mul_step;
    logic div_load;
    logic div_step;
    logic out_load;
  } zci_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } zci_sts_t;

endpackage

// ===== design/zci_ctrl.sv =====
// Sequencer for the zero-crossing interpolator: accept, multiply, divide, result load.
module zci_ctrl #(
  parameter int X_WIDTH = zci_pkg::DEF_X_WIDTH,
  parameter int Y_WIDTH = zci_pkg::DEF_Y_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  zci_pkg::zci_sts_t sts,
  output zci_pkg::zci_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam int MAX_STEPS = (X_WIDTH > Y_WIDTH) ? X_WIDTH : Y_WIDTH;
  localparam int CW        = $clog2(MAX_STEPS);

  localparam logic [CW-1:0] MUL_LAST = CW'(Y_WIDTH - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(X_WIDTH - 1);

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.accept   = in_valid && (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.hit) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold here until the output register can take the new result.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== design/zci_datapath.sv =====
// Datapath: sample history, crossing detection, shift-add multiplier, restoring divider.
module zci_datapath #(
  parameter int X_WIDTH     = zci_pkg::DEF_X_WIDTH,
  parameter int Y_WIDTH     = zci_pkg::DEF_Y_WIDTH,
  parameter int INDEX_WIDTH = zci_pkg::DEF_INDEX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [X_WIDTH-1:0]           in_sample_x,
  input  logic signed [Y_WIDTH-1:0]           in_sample_y,
  input  logic                                in_sample_valid,
  input  logic                                in_record_start,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic        [INDEX_WIDTH-1:0]       out_crossing_index,
  output logic signed [X_WIDTH-1:0]           out_zero_x,
  output logic                                out_rising,
  input  logic                                cfg_wr_en,
  input  logic [zci_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [zci_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
  input  zci_pkg::zci_cmd_t                   cmd,
  output zci_pkg::zci_sts_t                   sts
);

  // The product |dx| * |prev_y| stays below 2^(X+Y-1).
  localparam int PW = X_WIDTH + Y_WIDTH - 1;

  logic                   rise_en_r, fall_en_r;
  logic [X_WIDTH-1:0]     prev_x_r;
  logic [Y_WIDTH-1:0]     prev_y_r;
  logic                   have_prev_r;
  logic [INDEX_WIDTH-1:0] count_r;

  logic [X_WIDTH-1:0]     dx_mag_r;
  logic [Y_WIDTH-1:0]     py_mag_r;
  logic [Y_WIDTH-1:0]     dy_mag_r;
  logic                   neg_r;
  logic [X_WIDTH-1:0]     base_x_r;
  logic [INDEX_WIDTH-1:0] idx_r;
  logic                   dir_r;
  logic [PW-1:0]          acc_r;
  logic [Y_WIDTH-1:0]     rem_r;
  logic [X_WIDTH-1:0]     quo_r;

  logic                   out_valid_r;
  logic [INDEX_WIDTH-1:0] out_index_r;
  logic [X_WIDTH-1:0]     out_zero_x_r;
  logic                   out_rising_r;

  // Crossing detection on the presented sample.
  logic [INDEX_WIDTH-1:0] idx_eff;
  logic                   hp_eff;
  logic                   y_neg, y_zero, py_neg, py_zero, up, down;
  logic [X_WIDTH:0]       dx_w, dx_abs;
  logic [Y_WIDTH:0]       dy_w, dy_abs;
  logic [Y_WIDTH-1:0]     py_abs;

  assign idx_eff = in_record_start ? '0 : count_r;
  assign hp_eff  = in_record_start ? 1'b0 : have_prev_r;
  assign y_neg   = in_sample_y[Y_WIDTH-1];
  assign y_zero  = (in_sample_y == '0);
  assign py_neg  = prev_y_r[Y_WIDTH-1];
  assign py_zero = (prev_y_r == '0);
  assign up      = !y_neg && py_neg;
  assign down    = (y_neg || y_zero) && !py_neg && !py_zero;

  assign sts.hit = in_sample_valid && hp_eff &&
                   ((up && rise_en_r) || (down && fall_en_r));

  assign dx_w   = {in_sample_x[X_WIDTH-1], in_sample_x} - {prev_x_r[X_WIDTH-1], prev_x_r};
  assign dx_abs = dx_w[X_WIDTH] ? (~dx_w + (X_WIDTH+1)'(1)) : dx_w;
  assign dy_w   = {in_sample_y[Y_WIDTH-1], in_sample_y} - {prev_y_r[Y_WIDTH-1], prev_y_r};
  assign dy_abs = dy_w[Y_WIDTH] ? (~dy_w + (Y_WIDTH+1)'(1)) : dy_w;
  assign py_abs = py_neg ? (~prev_y_r + Y_WIDTH'(1)) : prev_y_r;

  // One restoring division step: bring down the next numerator bit.
  logic [Y_WIDTH:0] trial, diff;
  logic             ge;

  assign trial = {rem_r, quo_r[X_WIDTH-1]};
  assign diff  = trial - {1'b0, dy_mag_r};
  assign ge    = (trial >= {1'b0, dy_mag_r});

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_en_r   <= 1'b1;
      fall_en_r   <= 1'b1;
      have_prev_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          zci_pkg::REG_RISING_ENABLE:  rise_en_r <= cfg_wdata[0];
          zci_pkg::REG_FALLING_ENABLE: fall_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        count_r <= idx_eff + 1'b1;
        if (in_sample_valid) begin
          have_prev_r <= 1'b1;
        end else if (in_record_start) begin
          have_prev_r <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_sample_valid) begin
      prev_x_r <= in_sample_x;
      prev_y_r <= in_sample_y;
    end
    if (cmd.accept && sts.hit) begin
      dx_mag_r <= dx_abs[X_WIDTH-1:0];
      py_mag_r <= py_abs;
      dy_mag_r <= dy_abs[Y_WIDTH-1:0];
      neg_r    <= dx_w[X_WIDTH] ^ py_neg ^ dy_w[Y_WIDTH];
      base_x_r <= prev_x_r;
      idx_r    <= idx_eff;
      dir_r    <= up;
      acc_r    <= '0;
    end
    if (cmd.mul_step) begin
      acc_r    <= (acc_r << 1) + (py_mag_r[Y_WIDTH-1] ? PW'(dx_mag_r) : '0);
      py_mag_r <= py_mag_r << 1;
    end
    // The quotient fits in X bits, so the bits above them start as the remainder.
    if (cmd.div_load) begin
      rem_r <= {1'b0, acc_r[PW-1:X_WIDTH]};
      quo_r <= acc_r[X_WIDTH-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? diff[Y_WIDTH-1:0] : trial[Y_WIDTH-1:0];
      quo_r <= {quo_r[X_WIDTH-2:0], ge};
    end
    if (cmd.out_load) begin
      out_index_r  <= idx_r;
      out_zero_x_r <= neg_r ? (base_x_r + quo_r) : (base_x_r - quo_r);
      out_rising_r <= dir_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_crossing_index = out_index_r;
  assign out_zero_x         = out_zero_x_r;
  assign out_rising         = out_rising_r;

endmodule

// ===== design/zero_crossing_interpolator_top.sv =====
// Top level of the zero-crossing interpolator: controller plus datapath.
//
//   Channel   Direction  Handshake            Payload
//   in_       in         in_valid/in_stall    sample_x, sample_y, sample_valid, record_start
//   out_      out        out_valid/out_stall  crossing_index, zero_x, rising
//   cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// A sample that reports no crossing does not stall the input; the next can follow at once.
// A reported crossing keeps the input stalled through Y_WIDTH shift-add multiply steps,
// one load, X_WIDTH divide steps and one load.
// The result sits in an output register, so input transfers go on while it waits.
// A stalled output holds the finish step until the output register frees up.
// Reset is synchronous and active low.
module zero_crossing_interpolator_top #(
  parameter int X_WIDTH     = zci_pkg::DEF_X_WIDTH,
  parameter int Y_WIDTH     = zci_pkg::DEF_Y_WIDTH,
  parameter int INDEX_WIDTH = zci_pkg::DEF_INDEX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [X_WIDTH-1:0]           in_sample_x,
  input  logic signed [Y_WIDTH-1:0]           in_sample_y,
  input  logic                                in_sample_valid,
  input  logic                                in_record_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [INDEX_WIDTH-1:0]       out_crossing_index,
  output logic signed [X_WIDTH-1:0]           out_zero_x,
  output logic                                out_rising,
  input  logic                                cfg_wr_en,
  input  logic [zci_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [zci_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  zci_pkg::zci_cmd_t cmd;
  zci_pkg::zci_sts_t sts;

  zci_ctrl #(
    .X_WIDTH (X_WIDTH),
    .Y_WIDTH (Y_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  zci_datapath #(
    .X_WIDTH     (X_WIDTH),
    .Y_WIDTH     (Y_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_sample_x        (in_sample_x),
    .in_sample_y        (in_sample_y),
    .in_sample_valid    (in_sample_valid),
    .in_record_start    (in_record_start),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_crossing_index (out_crossing_index),
    .out_zero_x         (out_zero_x),
    .out_rising         (out_rising),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .sts                (sts)
  );

  // A new result never overwrites one that is still waiting for its transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending output");

  // A transfer that reports a crossing starts the multiply-divide sequence.
  a_busy_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.hit) |=> (in_stall && cmd.mul_step))
    else $error("crossing accepted without starting the interpolation");

  // Every finished interpolation shows up on the output the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule
